// ===== hdl/card_sector_access_check_top_defines.svh =====
// ----------------------------------------------------------------------------
// card_sector_access_check_top_defines.svh
// Assertion macros used by the checker file csac_checker.sv.
// ----------------------------------------------------------------------------
`ifndef CARD_SECTOR_ACCESS_CHECK_TOP_DEFINES_SVH
`define CARD_SECTOR_ACCESS_CHECK_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CSAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csac: property failed");

// antecedent implies consequent at a later cycle
`define CSAC_ASSERT_LAT3(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##3 (cons)) \
    else $error("csac: latency property failed");

`endif

// ===== hdl/csac_pkg.sv =====
// ----------------------------------------------------------------------------
// csac_pkg
// Beat types and command codes for the sector access check.
// ----------------------------------------------------------------------------
package csac_pkg;

  localparam logic [3:0] CMD_RD_DATA = 4'd0;
  localparam logic [3:0] CMD_WR_DATA = 4'd1;
  localparam logic [3:0] CMD_INCR    = 4'd2;
  localparam logic [3:0] CMD_DECR    = 4'd3;
  localparam logic [3:0] CMD_WR_KEYA = 4'd4;
  localparam logic [3:0] CMD_RD_KEYB = 4'd5;
  localparam logic [3:0] CMD_WR_KEYB = 4'd6;
  localparam logic [3:0] CMD_RD_BITS = 4'd7;
  localparam logic [3:0] CMD_WR_BITS = 4'd8;

  localparam logic [1:0] GRP_TRAILER = 2'd3;

  // large-sector group boundaries
  localparam logic [3:0] LRG_GRP1_START = 4'd5;
  localparam logic [3:0] LRG_GRP2_START = 4'd10;
  localparam logic [3:0] LRG_TRAILER    = 4'd15;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] access_word;
    logic [5:0]  sector_index;
    logic [3:0]  block_index;
    logic        key_is_b;
  } csac_req_t;

  typedef struct packed {
    logic allowed;
    logic bits_consistent;
    logic bad_index;
  } csac_rsp_t;

endpackage

// ===== hdl/card_sector_access_check_top.sv =====
// ----------------------------------------------------------------------------
// card_sector_access_check_top
// An accepted beat passes the s1, s2 and s3 valid registers before the rsp_valid_o strobe.
// Throughput: one beat per cycle once busy_o is low, set by the three-stage decision pipeline.
// busy_o is high only in reset and the first cycle after; then always low.
// Reset: rst_ni asynchronous active low clears all valid bits.
// ----------------------------------------------------------------------------
module card_sector_access_check_top
  import csac_pkg::*;
#(
  parameter int SMALL_SECTOR_COUNT = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  csac_req_t req_i,
  output logic      busy_o,
  output logic      rsp_valid_o,
  output csac_rsp_t rsp_o
);

  localparam logic [6:0] SmallCnt = 7'(SMALL_SECTOR_COUNT);

  logic busy_q;
  logic accept;

  // stage 1: decode
  logic       s1_vld_q;
  logic [3:0] s1_cmd_q, s1_cmd_d;
  logic       s1_kb_q, s1_kb_d;
  logic [2:0] s1_c_q, s1_c_d;
  logic [2:0] s1_t_q, s1_t_d;
  logic       s1_tr_q, s1_tr_d;
  logic       s1_cons_q, s1_cons_d;
  logic       s1_bad_q, s1_bad_d;

  // stage 2: permission
  logic s2_vld_q;
  logic s2_ok_q, s2_ok_d;
  logic s2_cons_q;
  logic s2_bad_q;

  // stage 3: result
  logic      s3_vld_q;
  csac_rsp_t s3_rsp_q, s3_rsp_d;

  logic        small_sec;
  logic [1:0]  grp;
  logic [11:0] inv_bits;
  logic [11:0] tru_bits;

  assign accept = start_i & ~busy_q;

  always_comb begin
    inv_bits  = req_i.access_word[11:0];
    tru_bits  = req_i.access_word[23:12];
    small_sec = {1'b0, req_i.sector_index} < SmallCnt;
    if (small_sec) begin
      grp = req_i.block_index[1:0];
    end else if (req_i.block_index < LRG_GRP1_START) begin
      grp = 2'd0;
    end else if (req_i.block_index < LRG_GRP2_START) begin
      grp = 2'd1;
    end else if (req_i.block_index < LRG_TRAILER) begin
      grp = 2'd2;
    end else begin
      grp = GRP_TRAILER;
    end
    s1_cmd_d  = req_i.command;
    s1_kb_d   = req_i.key_is_b;
    s1_c_d    = {tru_bits[{2'b10, grp}], tru_bits[{2'b01, grp}], tru_bits[{2'b00, grp}]};
    s1_t_d    = {tru_bits[11], tru_bits[7], tru_bits[3]};
    s1_tr_d   = (grp == GRP_TRAILER);
    s1_cons_d = ((inv_bits ^ tru_bits) == 12'hFFF);
    s1_bad_d  = small_sec & (req_i.block_index > 4'd3);
  end

  logic c1, c2, c3, t1, t2, t3, ka, kb;

  always_comb begin
    {c3, c2, c1} = s1_c_q;
    {t3, t2, t1} = s1_t_q;
    kb = s1_kb_q;
    ka = ~s1_kb_q;
    case (s1_cmd_q)
      CMD_RD_DATA: begin
        s2_ok_d = ~s1_tr_q &
                  ((ka & (~c3 | (~c1 & ~c2 & c3))) |
                   (kb & (~c3 | ((c1 ^ c2) & c3) | (~c1 & ~c2 & c3))));
      end
      CMD_WR_DATA: begin
        s2_ok_d = ~s1_tr_q &
                  ((ka & ~c1 & ~c2 & ~c3) |
                   (kb & ((~c1 & (c2 == c3)) | (c1 & ~c3))));
      end
      CMD_INCR: begin
        s2_ok_d = ~s1_tr_q &
                  ((ka & ~c1 & ~c2 & ~c3) | (kb & ~c3 & (c1 == c2)));
      end
      CMD_DECR: begin
        s2_ok_d = ~s1_tr_q & ((~c3 & (c1 == c2)) | (~c1 & ~c2 & c3));
      end
      CMD_WR_KEYA, CMD_WR_KEYB: begin
        s2_ok_d = (ka & ~t1 & ~t2) |
                  (kb & ((~t1 & t2 & t3) | (t1 & ~t2 & ~t3)));
      end
      CMD_RD_KEYB: begin
        s2_ok_d = ka & ~t1 & ~(t2 & t3);
      end
      CMD_RD_BITS: begin
        s2_ok_d = ka | (kb & ((t1 & ~t3) | (~t1 & t2 & t3) | (t1 & t3)));
      end
      CMD_WR_BITS: begin
        s2_ok_d = (ka & ~t1 & ~t2 & t3) |
                  (kb & t3 & ((~t1 & t2) | (t1 & ~t2)));
      end
      default: begin
        s2_ok_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    s3_rsp_d.allowed         = s2_ok_q & ~s2_bad_q;
    s3_rsp_d.bits_consistent = s2_cons_q;
    s3_rsp_d.bad_index       = s2_bad_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b1;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      busy_q   <= 1'b0;
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q  <= s1_cmd_d;
      s1_kb_q   <= s1_kb_d;
      s1_c_q    <= s1_c_d;
      s1_t_q    <= s1_t_d;
      s1_tr_q   <= s1_tr_d;
      s1_cons_q <= s1_cons_d;
      s1_bad_q  <= s1_bad_d;
    end
    if (s1_vld_q) begin
      s2_ok_q   <= s2_ok_d;
      s2_cons_q <= s1_cons_q;
      s2_bad_q  <= s1_bad_q;
    end
    if (s2_vld_q) begin
      s3_rsp_q <= s3_rsp_d;
    end
  end

  assign busy_o      = busy_q;
  assign rsp_valid_o = s3_vld_q;
  assign rsp_o       = s3_rsp_q;

endmodule

// ===== hdl/csac_checker.sv =====
// ----------------------------------------------------------------------------
// csac_checker
// Port-level checks on the sector access check, bound to the top level.
// ----------------------------------------------------------------------------
`include "card_sector_access_check_top_defines.svh"

module csac_checker
  import csac_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input csac_req_t req_i,
  input logic      busy_o,
  input logic      rsp_valid_o,
  input csac_rsp_t rsp_o
);

  logic acc;

  assign acc = start_i & ~busy_o;

  `CSAC_ASSERT_LAT3(a_beat_answered, acc, rsp_valid_o)
  `CSAC_ASSERT_IMP(a_no_spurious_rsp, rsp_valid_o, $past(acc, 3))
  `CSAC_ASSERT_IMP(a_bad_refused, rsp_valid_o && rsp_o.bad_index, !rsp_o.allowed)
  `CSAC_ASSERT_IMP(a_cons_matches, rsp_valid_o,
    rsp_o.bits_consistent == (($past(req_i.access_word[11:0], 3) ^
                                $past(req_i.access_word[23:12], 3)) == 12'hFFF))

endmodule

bind card_sector_access_check_top csac_checker u_csac_checker (.*);
